@@ rtl/ce_pkg.sv @@
// Shared types, constants and byte encoders for the code point encoder.
`timescale 1ns / 1ps
`default_nettype none

package ce_pkg;

  // Default sizes handed to the top level
  localparam int SLACK_WIDTH_DEF = 18;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Fixed field widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_BYTE_W = 8;
  localparam int SLACK_OUT_W = 18;
  localparam int OUT_DATA_W = 32;
  localparam int CP_W       = 21;

  // binary64 layout
  localparam int MANT_W = 52;
  localparam int EXP_W  = 11;
  localparam logic [EXP_W-1:0] EXP_BIAS    = 11'd1023;
  localparam logic [EXP_W-1:0] EXP_SPECIAL = 11'h7FF;
  localparam logic [EXP_W-1:0] EXP_TOP     = 11'd20;

  // Code point limits and encoding marks
  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_1BYTE    = 21'h00007F;
  localparam logic [CP_W-1:0] CP_2BYTE    = 21'h0007FF;
  localparam logic [CP_W-1:0] CP_BMP      = 21'h00FFFF;
  localparam logic [CP_W-1:0] CP_SUPP     = 21'h010000;
  localparam logic [7:0]      LEAD_2      = 8'hC0;
  localparam logic [7:0]      LEAD_3      = 8'hE0;
  localparam logic [7:0]      LEAD_4      = 8'hF0;
  localparam logic [7:0]      CONT_MARK   = 8'h80;
  localparam logic [15:0]     SURR_HI     = 16'hD800;
  localparam logic [15:0]     SURR_LO     = 16'hDC00;

  // Encoded bytes of one code point; last_idx is byte count minus one
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } ce_code_t;

  // One queue entry: everything the back end needs to emit an item
  typedef struct packed {
    logic [3:0][7:0]        bytes;
    logic [1:0]             last_idx;
    logic                   invalid;
    logic [SLACK_OUT_W-1:0] slack;
  } ce_entry_t;

  function automatic ce_code_t encode_utf8(input logic [CP_W-1:0] cp);
    ce_code_t r;
    r = '0;
    if (cp <= CP_1BYTE) begin
      r.bytes[0] = cp[7:0];
      r.last_idx = 2'd0;
    end else if (cp <= CP_2BYTE) begin
      r.bytes[0] = LEAD_2 | {3'b0, cp[10:6]};
      r.bytes[1] = CONT_MARK | {2'b0, cp[5:0]};
      r.last_idx = 2'd1;
    end else if (cp <= CP_BMP) begin
      r.bytes[0] = LEAD_3 | {4'b0, cp[15:12]};
      r.bytes[1] = CONT_MARK | {2'b0, cp[11:6]};
      r.bytes[2] = CONT_MARK | {2'b0, cp[5:0]};
      r.last_idx = 2'd2;
    end else begin
      r.bytes[0] = LEAD_4 | {5'b0, cp[20:18]};
      r.bytes[1] = CONT_MARK | {2'b0, cp[17:12]};
      r.bytes[2] = CONT_MARK | {2'b0, cp[11:6]};
      r.bytes[3] = CONT_MARK | {2'b0, cp[5:0]};
      r.last_idx = 2'd3;
    end
    return r;
  endfunction

  function automatic ce_code_t encode_utf16be(input logic [CP_W-1:0] cp);
    ce_code_t          r;
    logic [CP_W-1:0]   off;
    logic [15:0]       hi;
    logic [15:0]       lo;
    r   = '0;
    off = cp - CP_SUPP;
    hi  = SURR_HI | {6'b0, off[19:10]};
    lo  = SURR_LO | {6'b0, off[9:0]};
    if (cp <= CP_BMP) begin
      r.bytes[0] = cp[15:8];
      r.bytes[1] = cp[7:0];
      r.last_idx = 2'd1;
    end else begin
      r.bytes[0] = hi[15:8];
      r.bytes[1] = hi[7:0];
      r.bytes[2] = lo[15:8];
      r.bytes[3] = lo[7:0];
      r.last_idx = 2'd3;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ce_front.sv @@
// Front end: takes input beats, decodes the binary64 value, encodes and counts slack.
`timescale 1ns / 1ps
`default_nettype none

module ce_front #(
  parameter int SLACK_WIDTH = ce_pkg::SLACK_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [63:0]           s_tdata,
  input  wire logic                  s_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_data,
  output logic                       push,
  output ce_pkg::ce_entry_t          push_entry,
  input  wire logic                  full
);
  import ce_pkg::*;

  logic                   mode;
  logic                   st_valid;
  logic [CP_W-1:0]        st_cp;
  logic                   st_invalid;
  logic                   st_last;
  logic [SLACK_WIDTH-1:0] slack;

  logic                   sign;
  logic [EXP_W-1:0]       expo;
  logic [MANT_W-1:0]      mant;
  logic [EXP_W-1:0]       e_full;
  logic [4:0]             e;
  logic [4:0]             shamt;
  logic                   in_range;
  logic [19:0]            frac_mask;
  logic [CP_W-1:0]        val;
  logic                   is_zero;
  logic                   dec_ok;
  logic [CP_W-1:0]        dec_cp;

  ce_code_t                           code;
  logic [1:0]                         add;
  logic [SLACK_WIDTH:0]               sum;
  logic [SLACK_WIDTH-1:0]             slack_upd;
  logic [SLACK_WIDTH-1:0]             slack_shown;
  logic [SLACK_WIDTH+SLACK_OUT_W-1:0] slack_wide;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid) begin
      mode <= cfg_data;
    end
  end

  // Split the binary64 pattern and find the integer value
  assign sign     = s_tdata[63];
  assign expo     = s_tdata[62:52];
  assign mant     = s_tdata[51:0];
  assign e_full   = expo - EXP_BIAS;
  assign in_range = (expo >= EXP_BIAS) && (e_full <= EXP_TOP);
  assign e        = e_full[4:0];
  assign shamt    = EXP_TOP[4:0] - e;
  assign frac_mask = 20'hFFFFF >> e;
  assign val      = {1'b1, mant[51:32]} >> shamt;
  assign is_zero  = (expo == '0) && (mant == '0);

  // Negative zero passes; everything else must be a non-negative integer in range
  assign dec_ok = is_zero ||
                  ((expo != EXP_SPECIAL) && !sign && in_range &&
                   (mant[31:0] == '0) && ((mant[51:32] & frac_mask) == '0) &&
                   (val <= CP_MAX));
  assign dec_cp = is_zero ? '0 : val;

  // Decode stage register; advance when the queue has room
  assign push     = st_valid && !full;
  assign s_tready = !st_valid || !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      st_valid <= 1'b1;
    end else if (push) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      st_cp      <= dec_cp;
      st_invalid <= !dec_ok;
      st_last    <= s_tlast;
    end
  end

  // Encode and update the saturating slack count
  assign code      = mode ? encode_utf16be(st_cp) : encode_utf8(st_cp);
  assign add       = 2'd3 - code.last_idx;
  assign sum       = {1'b0, slack} + {{(SLACK_WIDTH - 1){1'b0}}, add};
  assign slack_upd = sum[SLACK_WIDTH] ? '1 : sum[SLACK_WIDTH-1:0];
  assign slack_shown = st_invalid ? slack : slack_upd;
  assign slack_wide  = {{SLACK_OUT_W{1'b0}}, slack_shown};

  always_ff @(posedge clk) begin
    if (rst) begin
      slack <= '0;
    end else if (push) begin
      slack <= st_last ? '0 : slack_shown;
    end
  end

  // Build the queue entry; a rejected value carries one zero byte
  always_comb begin
    push_entry.bytes    = st_invalid ? '0 : code.bytes;
    push_entry.last_idx = st_invalid ? 2'd0 : code.last_idx;
    push_entry.invalid  = st_invalid;
    push_entry.slack    = slack_wide[SLACK_OUT_W-1:0];
  end

  // Slack is empty after the final item of a string
  a_slack_clear: assert property (@(posedge clk) disable iff (rst)
    push && st_last |=> slack == '0)
    else $error("slack not cleared after end of string");

  // Stage register holds while the queue is full
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    st_valid && full |=> st_valid && $stable(st_cp))
    else $error("decode stage lost an item while stalled");

endmodule

`default_nettype wire

@@ rtl/ce_queue.sv @@
// Short queue of encoded items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module ce_queue #(
  parameter int DEPTH = ce_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ce_pkg::ce_entry_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output ce_pkg::ce_entry_t      pop_data,
  output logic                   empty
);
  import ce_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ce_entry_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

@@ rtl/ce_back.sv @@
// Back end: serializes queued items into output byte beats.
`timescale 1ns / 1ps
`default_nettype none

module ce_back (
  input  wire logic              clk,
  input  wire logic              rst,
  output logic                   pop,
  input  wire ce_pkg::ce_entry_t pop_data,
  input  wire logic              empty,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [31:0]            m_tdata,
  output logic                   m_tlast,
  output logic                   m_tuser
);
  import ce_pkg::*;

  localparam int PAD_W = OUT_DATA_W - OUT_BYTE_W - SLACK_OUT_W;

  logic       ent_valid;
  ce_entry_t  ent;
  logic [1:0] idx;
  logic       out_adv;
  logic       ent_done;

  // Emit one byte whenever the output register is free
  assign out_adv  = ent_valid && (!m_tvalid || m_tready);
  assign ent_done = out_adv && (idx == ent.last_idx);
  assign pop      = !empty && (!ent_valid || ent_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      ent_valid <= 1'b1;
      idx       <= '0;
    end else if (ent_done) begin
      ent_valid <= 1'b0;
    end else if (out_adv) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent <= pop_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      m_tdata <= {{PAD_W{1'b0}}, ent.slack, ent.bytes[idx]};
      m_tlast <= (idx == ent.last_idx);
      m_tuser <= ent.invalid;
    end
  end

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata[7:0] == '0))
    else $error("error beat must be a single zero byte");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    ent_valid |-> idx <= ent.last_idx)
    else $error("byte index past end of item");

endmodule

`default_nettype wire

@@ rtl/code_point_to_utf8_utf16_encoder.sv @@
// Top level: code point to UTF-8 / big-endian UTF-16 byte stream encoder.
//
//  channel  direction  beat contents
//  s_*      in         tdata: code_point_bits[63:0]; tlast: last_in_string
//  m_*      out        tdata: out_byte[7:0], slack_total[25:8], zero[31:26];
//                      tlast: last_byte; tuser: invalid_code_point
//  cfg_*    in         cfg_data: encoding_mode (0 UTF-8, 1 UTF-16BE)
//
// An input beat is taken every cycle while the queue has room; decode sits in
// one register stage and the queue holds QUEUE_DEPTH encoded items.
// The output side emits one byte per cycle from a single output register while
// bytes are queued and m_tready does not hold it off, so an item takes 1 to 4
// beats (its byte count); a rejected value takes one beat.
// Reset (rst, synchronous) clears the slack count, mode and all valid flags.
// Either side may stall at any time; the queue decouples them.
`timescale 1ns / 1ps
`default_nettype none

module code_point_to_utf8_utf16_encoder #(
  parameter int SLACK_WIDTH = ce_pkg::SLACK_WIDTH_DEF,
  parameter int QUEUE_DEPTH = ce_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [63:0] code_point_bits
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [7:0] out_byte, [25:8] slack_total, [31:26] zero
  output logic             m_tlast,
  output logic             m_tuser,   // [0] invalid_code_point
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);
  import ce_pkg::*;

  logic      push;
  ce_entry_t push_entry;
  logic      full;
  logic      pop;
  ce_entry_t pop_data;
  logic      empty;

  ce_front #(
    .SLACK_WIDTH(SLACK_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  ce_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  ce_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the code point to UTF-8 / UTF-16BE byte encoder.
`timescale 1ns / 1ps

module tb_top;

  // Narrow slack counter so that saturation is reached by long strings
  localparam int TB_SLACK_W  = 8;
  localparam int SLACK_OUT_W = 18;
  localparam longint unsigned SLACK_SAT = (64'd1 << TB_SLACK_W) - 64'd1;
  localparam int RUN_LIMIT   = 200000;
  localparam int MAX_REPORTS = 100;
  localparam int IDLE_PCT    = 30;

  // Encoding modes
  localparam logic MODE_UTF8    = 1'b0;
  localparam logic MODE_UTF16BE = 1'b1;

  // Code point limits and byte marks
  localparam logic [63:0] CP_LIMIT   = 64'h10FFFF;
  localparam logic [20:0] ONE_MAX    = 21'h7F;
  localparam logic [20:0] TWO_MAX    = 21'h7FF;
  localparam logic [20:0] BMP_MAX    = 21'hFFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [15:0] HI_SURR    = 16'hD800;
  localparam logic [15:0] LO_SURR    = 16'hDC00;
  localparam logic [7:0]  LEAD2      = 8'hC0;
  localparam logic [7:0]  LEAD3      = 8'hE0;
  localparam logic [7:0]  LEAD4      = 8'hF0;
  localparam logic [7:0]  CONT       = 8'h80;
  localparam logic [10:0] EXP_NONFIN = 11'h7FF;
  localparam logic [10:0] EXP_ONE    = 11'd1023;
  localparam logic [63:0] NEG_ZERO   = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] bits;
    logic        last;
  } cp_item_t;

  typedef struct packed {
    logic [7:0]             data;
    logic                   last;
    logic                   bad;
    logic [SLACK_OUT_W-1:0] slack;
  } enc_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  cp_item_t        code_points_to_send[$];
  enc_beat_t       expected_bytes[$];
  logic            tb_mode = MODE_UTF8;
  longint unsigned slack_cnt = 0;
  logic            no_idle = 1'b0;
  int              err_cnt = 0;
  int              cycle_cnt = 0;

  code_point_to_utf8_utf16_encoder #(
    .SLACK_WIDTH(TB_SLACK_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Exact binary64 check; returns {valid, code point}
  function automatic logic [21:0] decode_cp(input logic [63:0] bits);
    logic [10:0]  expo;
    logic [51:0]  mant;
    int unsigned  e;
    logic [63:0]  frac_mask;
    logic [63:0]  val;
    expo = bits[62:52];
    mant = bits[51:0];
    if (expo == EXP_NONFIN) return '0;
    if (expo == 11'd0 && mant == 52'd0) return {1'b1, 21'd0};
    if (bits[63]) return '0;
    if (expo < EXP_ONE) return '0;
    e = expo - EXP_ONE;
    if (e > 20) return '0;
    frac_mask = (64'd1 << (52 - e)) - 64'd1;
    if (({12'd0, mant} & frac_mask) != 64'd0) return '0;
    val = {11'd0, 1'b1, mant} >> (52 - e);
    if (val > CP_LIMIT) return '0;
    return {1'b1, val[20:0]};
  endfunction

  // Work out the output beats of one accepted code point and update the slack
  task automatic predict_encoding(input logic [63:0] bits, input logic last);
    logic [21:0]     dec;
    logic [20:0]     cp;
    logic [20:0]     off;
    logic [15:0]     hi;
    logic [15:0]     lo;
    logic [7:0]      b [0:3];
    int              n;
    longint unsigned add;
    enc_beat_t       eb;
    dec = decode_cp(bits);
    cp  = dec[20:0];
    if (!dec[21]) begin
      eb.data  = 8'd0;
      eb.last  = 1'b1;
      eb.bad   = 1'b1;
      eb.slack = slack_cnt[SLACK_OUT_W-1:0];
      expected_bytes.push_back(eb);
    end else begin
      for (int k = 0; k < 4; k++) b[k] = 8'd0;
      if (tb_mode == MODE_UTF16BE) begin
        if (cp <= BMP_MAX) begin
          b[0] = cp[15:8];
          b[1] = cp[7:0];
          n = 2;
        end else begin
          off  = cp - SUPP_BASE;
          hi   = HI_SURR + {6'd0, off[19:10]};
          lo   = LO_SURR + {6'd0, off[9:0]};
          b[0] = hi[15:8];
          b[1] = hi[7:0];
          b[2] = lo[15:8];
          b[3] = lo[7:0];
          n = 4;
        end
      end else begin
        if (cp <= ONE_MAX) begin
          b[0] = cp[7:0];
          n = 1;
        end else if (cp <= TWO_MAX) begin
          b[0] = LEAD2 | {3'd0, cp[10:6]};
          b[1] = CONT | {2'd0, cp[5:0]};
          n = 2;
        end else if (cp <= BMP_MAX) begin
          b[0] = LEAD3 | {4'd0, cp[15:12]};
          b[1] = CONT | {2'd0, cp[11:6]};
          b[2] = CONT | {2'd0, cp[5:0]};
          n = 3;
        end else begin
          b[0] = LEAD4 | {5'd0, cp[20:18]};
          b[1] = CONT | {2'd0, cp[17:12]};
          b[2] = CONT | {2'd0, cp[11:6]};
          b[3] = CONT | {2'd0, cp[5:0]};
          n = 4;
        end
      end
      // Saturating slack update
      add = 4 - n;
      if (slack_cnt > SLACK_SAT - add) slack_cnt = SLACK_SAT;
      else slack_cnt = slack_cnt + add;
      for (int k = 0; k < n; k++) begin
        eb.data  = b[k];
        eb.last  = (k == n - 1);
        eb.bad   = 1'b0;
        eb.slack = slack_cnt[SLACK_OUT_W-1:0];
        expected_bytes.push_back(eb);
      end
    end
    if (last) slack_cnt = 0;
  endtask

  task automatic flag_mismatch(input string what);
    if (err_cnt < MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    err_cnt++;
  endtask

  // Driver: present pending code points, idle at random
  always @(posedge clk) begin : drive_in
    cp_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_encoding(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (code_points_to_send.size() != 0 &&
            (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          it = code_points_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= it.bits;
          s_tlast  <= it.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output beat with the oldest expected byte
  always @(posedge clk) begin : watch_out
    enc_beat_t eb;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat tdata=%h tlast=%b tuser=%b",
                                  m_tdata, m_tlast, m_tuser));
        end else begin
          eb = expected_bytes.pop_front();
          if (m_tdata[7:0] != eb.data)
            flag_mismatch($sformatf("out_byte %h, want %h", m_tdata[7:0], eb.data));
          if (m_tdata[25:8] != eb.slack)
            flag_mismatch($sformatf("slack_total %0d, want %0d", m_tdata[25:8], eb.slack));
          if (m_tlast != eb.last)
            flag_mismatch($sformatf("last_byte %b, want %b", m_tlast, eb.last));
          if (m_tuser != eb.bad)
            flag_mismatch($sformatf("invalid_code_point %b, want %b", m_tuser, eb.bad));
        end
      end
      m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] cp_bits(input int unsigned cp);
    return $realtobits(real'(cp));
  endfunction

  // Valid code point, ascii_pct percent of them single-byte ASCII
  function automatic logic [63:0] rand_valid_bits(input int unsigned ascii_pct);
    int unsigned cp;
    if ($urandom_range(99) < ascii_pct) begin
      cp = $urandom_range(127);
    end else begin
      case ($urandom_range(5))
        0: cp = $urandom_range(32'h7FF, 32'h80);
        1: cp = $urandom_range(32'hFFFF, 32'h800);
        2: cp = $urandom_range(32'hDFFF, 32'hD800);
        3: cp = $urandom_range(32'h10FFFF, 32'h10000);
        4: cp = $urandom_range(32'hFFFF);
        default: begin
          case ($urandom_range(6))
            0: cp = 32'h0;
            1: cp = 32'h7F;
            2: cp = 32'h80;
            3: cp = 32'h7FF;
            4: cp = 32'h800;
            5: cp = 32'hFFFF;
            default: cp = 32'h10FFFF;
          endcase
        end
      endcase
    end
    if (cp == 0 && $urandom_range(1) == 1) return NEG_ZERO;
    return cp_bits(cp);
  endfunction

  // Rejected values of every kind, plus fully random patterns
  function automatic logic [63:0] rand_bad_bits();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(7))
      0: return {r[63], EXP_NONFIN, 52'd0};
      1: return {r[63], EXP_NONFIN, r[51:1], 1'b1};
      2: return $realtobits(-real'($urandom_range(32'h10FFFF, 1)));
      3: return cp_bits($urandom_range(32'h1FFFFF, 32'h110000));
      4: return {1'b0, 11'($urandom_range(2046, 1044)), r[51:0]};
      5: begin
        if (r[0]) return $realtobits(real'($urandom_range(32'h10FFFF)) + 0.5);
        return cp_bits($urandom_range(32'h10FFFF, 1)) | 64'd1;
      end
      6: return {r[63], 11'($urandom_range(1022)), r[51:1], 1'b1};
      default: return r;
    endcase
  endfunction

  task automatic queue_cp(input logic [63:0] bits, input logic last);
    cp_item_t it;
    it.bits = bits;
    it.last = last;
    code_points_to_send.push_back(it);
  endtask

  // Random strings: mostly short, some long enough to saturate the slack
  task automatic queue_random_strings(input int n_items);
    int          cnt;
    int          len;
    int unsigned ascii_pct;
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(99) < 8) begin
        len = $urandom_range(140, 100);
        ascii_pct = 75;
      end else begin
        len = $urandom_range(8, 1);
        ascii_pct = 25;
      end
      // Cut the final string so that the phase sends exactly n_items
      if (len > n_items - cnt) len = n_items - cnt;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 85) queue_cp(rand_valid_bits(ascii_pct), i == len - 1);
        else queue_cp(rand_bad_bits(), i == len - 1);
      end
      cnt += len;
    end
  endtask

  // Hold until every item is sent and every expected byte has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (code_points_to_send.size() != 0 || s_tvalid || expected_bytes.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    tb_mode = m;
    @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed UTF-8: range edges, surrogates, zeros and every rejected class
    write_mode(MODE_UTF8);
    queue_cp(cp_bits(0), 1'b0);
    queue_cp(NEG_ZERO, 1'b0);
    queue_cp(cp_bits(32'h7F), 1'b0);
    queue_cp(cp_bits(32'h80), 1'b0);
    queue_cp(cp_bits(32'h7FF), 1'b0);
    queue_cp(cp_bits(32'h800), 1'b0);
    queue_cp(cp_bits(32'hD800), 1'b0);
    queue_cp(cp_bits(32'hDFFF), 1'b0);
    queue_cp(cp_bits(32'hFFFF), 1'b0);
    queue_cp(cp_bits(32'h10000), 1'b0);
    queue_cp(cp_bits(32'h10FFFF), 1'b1);
    queue_cp(cp_bits(32'h110000), 1'b0);
    queue_cp({1'b0, EXP_NONFIN, 52'd0}, 1'b0);
    queue_cp({1'b1, EXP_NONFIN, 52'd0}, 1'b0);
    queue_cp({1'b0, EXP_NONFIN, 1'b1, 51'd0}, 1'b0);
    queue_cp($realtobits(-1.0), 1'b0);
    queue_cp($realtobits(0.5), 1'b0);
    queue_cp(64'd1, 1'b0);
    queue_cp($realtobits(1.5), 1'b0);
    queue_cp(cp_bits(32'h200000), 1'b0);
    queue_cp({64{1'b1}}, 1'b1);
    wait_drained();

    // Directed UTF-16BE: plane edges and surrogate values
    write_mode(MODE_UTF16BE);
    queue_cp(cp_bits(0), 1'b0);
    queue_cp(cp_bits(32'hDC00), 1'b0);
    queue_cp(cp_bits(32'hFFFF), 1'b0);
    queue_cp(cp_bits(32'h10000), 1'b0);
    queue_cp(cp_bits(32'h10FFFF), 1'b1);
    wait_drained();

    // Random phases in both modes, one of them with no idling at all
    write_mode(MODE_UTF8);
    queue_random_strings(115);
    wait_drained();
    write_mode(MODE_UTF16BE);
    queue_random_strings(115);
    wait_drained();
    no_idle = 1'b1;
    write_mode(MODE_UTF8);
    queue_random_strings(115);
    wait_drained();
    no_idle = 1'b0;
    write_mode(MODE_UTF16BE);
    queue_random_strings(115);
    wait_drained();

    repeat (20) @(negedge clk);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
